FILE: rtl/lz_window_decompressor_assert.svh
`ifndef LZ_WINDOW_DECOMPRESSOR_ASSERT_SVH
`define LZ_WINDOW_DECOMPRESSOR_ASSERT_SVH

// condition implies property in the same cycle
`define LZWD_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// condition implies property in the next cycle
`define LZWD_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

FILE: rtl/lzwd_pkg.sv
package lzwd_pkg;

  localparam int HISTORY_DEPTH_DEF = 2048;
  localparam int SIZE_BITS_DEF     = 24;
  localparam int CFG_W             = 24;
  localparam int TOTAL_W           = 24;
  localparam int DIST_BITS         = 11;
  localparam int LEN_W             = 8;
  localparam int IN_TDATA_W        = 8;
  localparam int OUT_TDATA_W       = 64;
  localparam int OUT_TUSER_W       = 3;

  localparam logic [DIST_BITS-1:0] DIST_MASK = 11'h7ff;
  localparam logic [4:0]           LEN_MASK  = 5'h1f;

  typedef enum logic [2:0] {
    PH_FLAG     = 3'd0,
    PH_LIT1     = 3'd1,
    PH_LIT2     = 3'd2,
    PH_LIT3     = 3'd3,
    PH_MATCH_HI = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_BYTE_RD,
    ST_BYTE_WR,
    ST_EMIT,
    ST_STATUS
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic byte_rd;
    logic byte_wr;
    logic emit;
    logic status;
  } lzwd_cmd_t;

  typedef struct packed {
    logic job_bytes;
    logic job_match;
    logic need_status;
    logic word_full;
    logic job_more;
    logic out_free;
  } lzwd_stat_t;

endpackage

FILE: rtl/lzwd_ram.sv
module lzwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/lzwd_ctrl.sv
module lzwd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  lzwd_pkg::lzwd_stat_t st,
  output lzwd_pkg::lzwd_cmd_t  cmd
);
  import lzwd_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (st.job_bytes) begin
          state_next = st.job_match ? ST_BYTE_RD : ST_BYTE_WR;
        end else if (st.need_status) begin
          state_next = ST_STATUS;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_BYTE_RD: begin
        cmd.byte_rd = 1'b1;
        state_next  = ST_BYTE_WR;
      end
      ST_BYTE_WR: begin
        cmd.byte_wr = 1'b1;
        if (st.word_full) begin
          state_next = ST_EMIT;
        end else begin
          state_next = st.job_match ? ST_BYTE_RD : ST_BYTE_WR;
        end
      end
      ST_EMIT: begin
        cmd.emit = st.out_free;
        if (st.out_free) begin
          if (st.job_more) begin
            state_next = st.job_match ? ST_BYTE_RD : ST_BYTE_WR;
          end else if (st.need_status) begin
            state_next = ST_STATUS;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_STATUS: begin
        cmd.status = st.out_free;
        if (st.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/lzwd_datapath.sv
module lzwd_datapath #(
  parameter int HISTORY_DEPTH = lzwd_pkg::HISTORY_DEPTH_DEF,
  parameter int SIZE_BITS     = lzwd_pkg::SIZE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [lzwd_pkg::IN_TDATA_W-1:0]   s_tdata,
  input  logic                              s_tlast,
  input  logic                              cfg_valid,
  input  logic [lzwd_pkg::CFG_W-1:0]        cfg_data,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [lzwd_pkg::OUT_TDATA_W-1:0]  m_tdata,
  output logic                              m_tlast,
  output logic [lzwd_pkg::OUT_TUSER_W-1:0]  m_tuser,
  input  lzwd_pkg::lzwd_cmd_t               cmd,
  output lzwd_pkg::lzwd_stat_t              st
);
  import lzwd_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);

  // frame state
  logic [SIZE_BITS-1:0] out_size, pos;
  logic [7:0]           flags;
  logic [3:0]           fbl;
  phase_t               phase;
  logic [23:0]          held;
  logic                 stopped;

  // job of the current source byte
  logic                 job_bytes, job_match, trunc, cut, endf, mid;
  logic [LEN_W-1:0]     left;
  logic [DIST_BITS-1:0] copy_dist;
  logic [31:0]          tok;
  logic [31:0]          word;
  logic [2:0]           fill;
  logic                 badw;

  // output register
  logic [31:0]          o_word;
  logic [2:0]           o_vb;
  logic [TOTAL_W-1:0]   o_total;
  logic                 o_last, o_done, o_bad, o_trunc;

  // decode of an accepted byte
  logic [SIZE_BITS-1:0] room;
  logic [7:0]           b;
  logic [5:0]           len_q;
  logic [LEN_W-1:0]     len_raw;
  logic [3:0]           fbl_dec;
  phase_t               ph_n;
  logic [23:0]          held_n;
  logic [7:0]           flags_n;
  logic [3:0]           fbl_n;
  logic                 stop_n, jb_n, jm_n, trunc_n, cut_n;
  logic [LEN_W-1:0]     left_n;
  logic [31:0]          tok_n;

  // ring access
  logic [AW-1:0]        raddr;
  logic [7:0]           rdata, wval;
  logic                 bad_now;

  assign b       = s_tdata[7:0];
  assign room    = (out_size > pos) ? out_size - pos : '0;
  assign len_q   = {1'b0, b[7:3] & LEN_MASK} + 6'd1;
  assign len_raw = {len_q, 2'b00};
  assign fbl_dec = fbl - 4'd1;

  always_comb begin
    ph_n    = phase;
    held_n  = held;
    flags_n = flags;
    fbl_n   = fbl;
    stop_n  = stopped;
    jb_n    = 1'b0;
    jm_n    = 1'b0;
    trunc_n = 1'b0;
    cut_n   = 1'b0;
    left_n  = '0;
    tok_n   = '0;
    if (!stopped) begin
      case (phase)
        PH_LIT1: begin
          held_n = held | {8'd0, b, 8'd0};
          ph_n   = PH_LIT2;
        end
        PH_LIT2: begin
          held_n = held | {b, 16'd0};
          ph_n   = PH_LIT3;
        end
        PH_LIT3: begin
          tok_n = {b, held};
          if (room < SIZE_BITS'(4)) begin
            left_n  = LEN_W'(room[2:0]);
            trunc_n = 1'b1;
          end else begin
            left_n = LEN_W'(4);
          end
          if (left_n != '0) jb_n = 1'b1;
          else              cut_n = 1'b1;
          ph_n   = PH_FLAG;
          held_n = '0;
        end
        PH_MATCH_HI: begin
          left_n = len_raw;
          if (SIZE_BITS'(len_raw) > room) begin
            left_n  = room[LEN_W-1:0];
            trunc_n = 1'b1;
          end
          if (left_n != '0) begin
            jb_n = 1'b1;
            jm_n = 1'b1;
          end else begin
            cut_n = trunc_n;
          end
          ph_n   = PH_FLAG;
          held_n = '0;
        end
        default: begin
          ph_n = PH_FLAG;
          if (pos >= out_size) begin
            stop_n = 1'b1;
          end else if (fbl == 4'd0) begin
            flags_n = b;
            fbl_n   = 4'd8;
          end else begin
            fbl_n = fbl_dec;
            if (!flags[fbl_dec[2:0]]) begin
              if (({1'b0, pos} + (SIZE_BITS+1)'(4)) > {1'b0, out_size}) begin
                stop_n = 1'b1;
                cut_n  = 1'b1;
              end else begin
                held_n = {16'd0, b};
                ph_n   = PH_LIT1;
              end
            end else begin
              held_n = {16'd0, b};
              ph_n   = PH_MATCH_HI;
            end
          end
        end
      endcase
    end
  end

  // copy source: zero or too-far distance reads as zero
  assign bad_now = (copy_dist == '0) || (SIZE_BITS'(copy_dist) > pos);
  assign raddr   = pos[AW-1:0] - AW'(copy_dist);
  assign wval    = job_match ? (bad_now ? 8'd0 : rdata) : 8'(tok >> {fill[1:0], 3'b000});

  lzwd_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.byte_wr),
    .waddr (pos[AW-1:0]),
    .wdata (wval),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_size  <= '0;
      pos       <= '0;
      flags     <= '0;
      fbl       <= '0;
      phase     <= PH_FLAG;
      held      <= '0;
      stopped   <= 1'b0;
      job_bytes <= 1'b0;
      job_match <= 1'b0;
      cut       <= 1'b0;
      endf      <= 1'b0;
      left      <= '0;
      fill      <= '0;
      word      <= '0;
      badw      <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_valid) out_size <= SIZE_BITS'(cfg_data);

      if (cmd.accept) begin
        phase     <= ph_n;
        held      <= held_n;
        flags     <= flags_n;
        fbl       <= fbl_n;
        stopped   <= stop_n;
        job_bytes <= jb_n;
        job_match <= jm_n;
        trunc     <= trunc_n;
        cut       <= cut_n;
        endf      <= s_tlast;
        mid       <= (ph_n inside {[PH_LIT1:PH_MATCH_HI]});
        left      <= left_n;
        tok       <= tok_n;
        copy_dist <= {b[2:0], held[7:0]} & DIST_MASK;
        word      <= '0;
        fill      <= '0;
        badw      <= 1'b0;
      end

      if (cmd.byte_wr) begin
        pos  <= pos + SIZE_BITS'(1);
        word <= word | (32'(wval) << {fill[1:0], 3'b000});
        fill <= fill + 3'd1;
        left <= left - LEN_W'(1);
        badw <= badw | (job_match & bad_now);
      end

      if (m_tready) m_tvalid <= 1'b0;

      if (cmd.emit) begin
        m_tvalid <= 1'b1;
        o_word   <= word;
        o_vb     <= fill;
        o_total  <= TOTAL_W'(pos);
        o_last   <= (left == '0) && !(cut || endf);
        o_done   <= 1'b0;
        o_bad    <= badw;
        o_trunc  <= trunc;
        word     <= '0;
        fill     <= '0;
        badw     <= 1'b0;
        if (left == '0) job_bytes <= 1'b0;
      end

      if (cmd.status) begin
        m_tvalid <= 1'b1;
        o_word   <= '0;
        o_vb     <= '0;
        o_total  <= TOTAL_W'(pos);
        o_last   <= 1'b1;
        o_done   <= endf;
        o_bad    <= 1'b0;
        o_trunc  <= cut | (endf & mid);
        if (endf) begin
          pos     <= '0;
          flags   <= '0;
          fbl     <= '0;
          phase   <= PH_FLAG;
          held    <= '0;
          stopped <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    st.job_bytes   = job_bytes;
    st.job_match   = job_match;
    st.need_status = cut | endf;
    st.word_full   = (fill == 3'd3) || (left == LEN_W'(1));
    st.job_more    = (left != '0);
    st.out_free    = !m_tvalid || m_tready;
  end

  assign m_tdata = {5'd0, o_total, o_vb, o_word};
  assign m_tlast = o_last;
  assign m_tuser = {o_trunc, o_bad, o_done};

endmodule

FILE: rtl/lz_window_decompressor.sv
// channel | dir | handshake          | payload
// s       | in  | s_tvalid/s_tready  | s_tdata: in_byte; s_tlast: source_end
// m       | out | m_tvalid/m_tready  | m_tdata, m_tlast: run_last, m_tuser: flags
// cfg     | in  | cfg_valid/cfg_ready| cfg_data: out_size
// A literal group writes its bytes into the history ring and packs them into result
// words; a match copies each byte by a registered read of the history RAM, then a
// write, and each full or final result word is emitted from the emit state.
// rst is synchronous and clears the frame state; the history RAM is not cleared.
// A stalled m_tready holds the machine in its emit or status state.
module lz_window_decompressor #(
  parameter int HISTORY_DEPTH = lzwd_pkg::HISTORY_DEPTH_DEF,
  parameter int SIZE_BITS     = lzwd_pkg::SIZE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [lzwd_pkg::IN_TDATA_W-1:0]   s_tdata,   // [7:0] in_byte
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [31:0] out_word, [34:32] valid_bytes, [58:35] total_bytes, rest zero
  output logic [lzwd_pkg::OUT_TDATA_W-1:0]  m_tdata,
  output logic                              m_tlast,
  // [0] frame_done, [1] bad_distance, [2] truncated
  output logic [lzwd_pkg::OUT_TUSER_W-1:0]  m_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lzwd_pkg::CFG_W-1:0]        cfg_data
);
  import lzwd_pkg::*;

  lzwd_cmd_t  cmd;
  lzwd_stat_t st;

  assign cfg_ready = 1'b1;

  lzwd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  lzwd_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .SIZE_BITS     (SIZE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

FILE: rtl/lzwd_checker.sv
`include "lz_window_decompressor_assert.svh"

module lzwd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tlast,
  input logic [2:0]  m_tuser
);

  `LZWD_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid, "output word dropped")
  `LZWD_ASSERT_NOW(a_vb_range, clk, rst, m_tvalid, m_tdata[34:32] <= 3'd4, "valid_bytes over 4")
  `LZWD_ASSERT_NOW(a_done_status, clk, rst, m_tvalid && m_tuser[0], m_tlast && (m_tdata[34:32] == 3'd0) && (m_tdata[31:0] == 32'd0) && !m_tuser[1], "frame_done on non-status word")
  `LZWD_ASSERT_NOW(a_status_last, clk, rst, m_tvalid && (m_tdata[34:32] == 3'd0), m_tlast && (m_tdata[31:0] == 32'd0), "status word not last or not zero")

endmodule

bind lz_window_decompressor lzwd_checker u_lzwd_checker (.*);
